>>> src/tng_pkg.sv
package tng_pkg;

   localparam logic [1:0] WAVE_SQUARE = 2'd0;
   localparam logic [1:0] WAVE_NOISE  = 2'd1;
   localparam logic [1:0] WAVE_SINE   = 2'd2;

   localparam logic [1:0] CSR_WAVE_TYPE     = 2'd0;
   localparam logic [1:0] CSR_PHASE_STEP    = 2'd1;
   localparam logic [1:0] CSR_LENGTH_FRAMES = 2'd2;

   localparam logic signed [15:0] SQUARE_AMP   = 16'sd9830;
   localparam logic signed [15:0] NOISE_OFFSET = 16'sd8192;
   localparam logic [15:0]        NOISE_SEED   = 16'hACE1;
   localparam logic [15:0]        NOISE_TAPS   = 16'hB400;
   localparam logic [14:0]        MAG_MAX      = 15'd16384;

   localparam longint unsigned TWO_PI_Q29 = 64'd3373259426;
   localparam longint unsigned HALF_TURN  = 64'h8000_0000;
   localparam longint unsigned QUART_TURN = 64'h4000_0000;
   localparam longint          ONE_Q30    = 64'sd1073741824;
   localparam longint unsigned SINE_AMP   = 64'd16384;

   // angle t in turns, Q32; result round(16384 * sin(2 pi t))
   function automatic logic signed [15:0] sine_value(input longint unsigned t_in);
      longint unsigned t;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned v;
      logic            neg;
      t   = t_in;
      neg = 1'b0;
      if (t >= HALF_TURN) begin
         neg = 1'b1;
         t   = t - HALF_TURN;
      end
      if (t > QUART_TURN) begin
         t = HALF_TURN - t;
      end
      x    = (t * TWO_PI_Q29) >> 31;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      v = (longint'(sum) * SINE_AMP + 64'd536870912) >> 30;
      return neg ? -16'(signed'(v)) : 16'(signed'(v));
   endfunction

endpackage

>>> src/tone_noise_generator_with_fade.sv
// Path: a playing item goes through S_TAB, S_RAW, S_LOAD, then a bit-serial
//    multiply and bit-serial divide for the fade, then S_DONE; a silent item
//    goes straight to S_DONE. One item is in work at a time: a new item is taken
//    only after the last result is loaded, which waits while a held one is not taken.
// Reset: synchronous, active high; clears the CSRs, state, phase and index, seeds the
//    noise register with 0xACE1 and leaves the block idle.
module tone_noise_generator_with_fade #(
   parameter int SINE_TABLE_ENTRIES = 256,
   parameter int SAMPLE_BITS        = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] active
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import tng_pkg::*;

   localparam int IDX_BITS = $clog2(SINE_TABLE_ENTRIES);
   localparam int NUM_BITS = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int SHL      = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
   localparam int SHR      = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

   typedef enum logic [2:0] {
      S_IDLE, S_TAB, S_RAW, S_LOAD, S_MUL, S_DIV, S_DONE
   } state_type;

   state_type state_ff;

   logic [1:0]  wave_ff;
   logic [31:0] step_ff;
   logic [15:0] len_ff;

   logic [15:0] idx_ff;
   logic [31:0] phase_ff;
   logic [15:0] lfsr_ff;
   logic        playing_ff;

   logic [IDX_BITS-1:0]  k_ff;
   logic signed [15:0]   sine_ff;
   logic [14:0]          mag_ff;
   logic                 neg_ff;
   logic                 last_ff;
   logic                 active_ff;
   logic [31:0]          pm_ff;
   logic [15:0]          rem_ff;
   logic [14:0]          dq_ff;
   logic [3:0]           cnt_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_sample_ff;
   logic        rsp_last_ff;
   logic        rsp_active_ff;

   logic signed [15:0] sine_rom [SINE_TABLE_ENTRIES];

   for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++) begin : g_sine
      localparam longint unsigned T = (64'(g) << 32) / SINE_TABLE_ENTRIES;
      assign sine_rom[g] = sine_value(T);
   end

   logic                     restart;
   logic [15:0]              idx_in;
   logic [31:0]              phase_in;
   logic                     go_in;
   logic [32+NUM_BITS-1:0]   kprod;
   logic [15:0]              lfsr_in;
   logic signed [15:0]       raw;
   logic [14:0]              mag_in;
   logic [16:0]              psum;
   logic [31:0]              pm_in;
   logic [16:0]              trial;
   logic                     ge;
   logic signed [15:0]       faded;
   logic signed [23:0]       faded_wide;
   logic [15:0]              sample_in;
   logic                     rsp_load;

   always_comb begin
      restart  = req_tdata[0];
      idx_in   = restart ? 16'd0 : idx_ff;
      phase_in = restart ? 32'd0 : phase_ff;
      go_in    = (restart ? (len_ff != 16'd0) : playing_ff) && (idx_in < len_ff);

      kprod = (32+NUM_BITS)'(phase_ff) * (32+NUM_BITS)'(SINE_TABLE_ENTRIES);

      lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? NOISE_TAPS : 16'd0);
      case (wave_ff)
         WAVE_SQUARE: raw = phase_ff[31] ? -SQUARE_AMP : SQUARE_AMP;
         WAVE_NOISE:  raw = signed'({2'b00, lfsr_in[15:2]}) - NOISE_OFFSET;
         default:     raw = sine_ff;
      endcase
      mag_in = raw[15] ? 15'(-raw) : 15'(raw);

      psum  = {1'b0, pm_ff[31:16]} + (pm_ff[0] ? {2'b00, mag_ff} : 17'd0);
      pm_in = {psum, pm_ff[15:1]};

      trial = {rem_ff, dq_ff[14]};
      ge    = trial >= {1'b0, len_ff};

      faded      = neg_ff ? -signed'({1'b0, dq_ff}) : signed'({1'b0, dq_ff});
      faded_wide = (24'(faded) <<< SHL) >>> SHR;
      sample_in  = faded_wide[15:0];

      rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wave_ff       <= WAVE_SQUARE;
         step_ff       <= '0;
         len_ff        <= '0;
         idx_ff        <= '0;
         phase_ff      <= '0;
         lfsr_ff       <= NOISE_SEED;
         playing_ff    <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_WAVE_TYPE:     wave_ff <= csr_wdata[1:0];
               CSR_PHASE_STEP:    step_ff <= csr_wdata;
               CSR_LENGTH_FRAMES: len_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  idx_ff     <= idx_in;
                  phase_ff   <= phase_in;
                  playing_ff <= go_in;
                  if (go_in) begin
                     state_ff <= S_TAB;
                  end else begin
                     dq_ff     <= '0;
                     neg_ff    <= 1'b0;
                     last_ff   <= 1'b0;
                     active_ff <= 1'b0;
                     state_ff  <= S_DONE;
                  end
               end
            end
            S_TAB: begin
               k_ff     <= kprod[32 +: IDX_BITS];
               state_ff <= S_RAW;
            end
            S_RAW: begin
               sine_ff  <= sine_rom[k_ff];
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (wave_ff == WAVE_NOISE) begin
                  lfsr_ff <= lfsr_in;
               end
               mag_ff    <= mag_in;
               neg_ff    <= raw[15];
               pm_ff     <= {16'd0, len_ff - idx_ff};
               last_ff   <= (17'(idx_ff) + 17'd1) == {1'b0, len_ff};
               active_ff <= 1'b1;
               if ((17'(idx_ff) + 17'd1) == {1'b0, len_ff}) begin
                  playing_ff <= 1'b0;
               end
               idx_ff    <= idx_ff + 16'd1;
               phase_ff  <= phase_ff + step_ff;
               cnt_ff    <= '0;
               state_ff  <= S_MUL;
            end
            S_MUL: begin
               pm_ff <= pm_in;
               if (cnt_ff == 4'd15) begin
                  rem_ff   <= {1'b0, pm_in[29:15]};
                  dq_ff    <= pm_in[14:0];
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_DIV: begin
               rem_ff <= ge ? 16'(trial - {1'b0, len_ff}) : trial[15:0];
               dq_ff  <= {dq_ff[13:0], ge};
               if (cnt_ff == 4'd14) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_sample_ff <= sample_in;
                  rsp_last_ff   <= last_ff;
                  rsp_active_ff <= active_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_last_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last item without active");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("silent item with nonzero sample");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < len_ff)
      else $error("divider remainder out of range");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> mag_ff <= MAG_MAX)
      else $error("raw magnitude out of range");

   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && cnt_ff != 4'd14 |=> state_ff == S_DIV)
      else $error("divider left early");
`endif

endmodule
